// ===== rtl/lkfs_pkg.sv =====
package lkfs_pkg;

    // Key geometry
    localparam int unsigned KEY_LIMIT   = 16;
    localparam int unsigned STORE_DEPTH = KEY_LIMIT - 1;
    localparam int unsigned HEX_DIGITS  = 15;
    localparam int unsigned LEN_W       = 5;
    localparam int unsigned IDX_W       = 4;

    // FNV-1a 64-bit constants
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(KEY_LIMIT);
    localparam logic [LEN_W-1:0] LEN_STORE = LEN_W'(STORE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_HEX_LAST = IDX_W'(HEX_DIGITS - 1);

    typedef enum logic {
        S_ABSORB,
        S_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic absorb;
        logic emit;
        logic clear;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic last_char;
    } t_sts;

    // Nibble to uppercase ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        begin
            case (nib)
                4'h0: ch = 8'h30;
                4'h1: ch = 8'h31;
                4'h2: ch = 8'h32;
                4'h3: ch = 8'h33;
                4'h4: ch = 8'h34;
                4'h5: ch = 8'h35;
                4'h6: ch = 8'h36;
                4'h7: ch = 8'h37;
                4'h8: ch = 8'h38;
                4'h9: ch = 8'h39;
                4'hA: ch = 8'h41;
                4'hB: ch = 8'h42;
                4'hC: ch = 8'h43;
                4'hD: ch = 8'h44;
                4'hE: ch = 8'h45;
                default: ch = 8'h46;
            endcase
            return ch;
        end
    endfunction

endpackage

// ===== rtl/long_key_fnv1a_shortener.sv =====
// Channel | Handshake          | Payload
// --------+--------------------+--------------------------------------------
// in      | i_valid / o_stall  | i_key_byte[7:0], i_final_byte
// out     | o_valid / i_stall  | o_out_char[7:0], o_was_hashed, o_final_char
//
// Each key byte is absorbed with one FNV-1a step.
// After the last byte the input stalls while 1 to 15 characters drain
// through the output register, one per cycle when the output does not stall;
// then byte intake resumes.
// Reset is synchronous and active low; it restores the FNV offset basis.
// A stall on the output holds the drain; the input stays stalled meanwhile.
module long_key_fnv1a_shortener (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_key_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_was_hashed,
    output logic       o_final_char
);
    import lkfs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    lkfs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_final_byte (i_final_byte),
        .o_stall      (o_stall),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    // Hash, buffer and output register
    lkfs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_key_byte   (i_key_byte),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_was_hashed (o_was_hashed),
        .o_final_char (o_final_char)
    );

endmodule

// ===== rtl/lkfs_ctrl.sv =====
module lkfs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_final_byte,
    output logic          o_stall,
    input  lkfs_pkg::t_sts i_sts,
    output lkfs_pkg::t_cmd o_cmd
);
    import lkfs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ABSORB;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_ABSORB: begin
                o_stall      = 1'b0;
                o_cmd.absorb = i_valid;
                if (i_valid && i_final_byte) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit  = i_sts.out_free;
                o_cmd.clear = i_sts.out_free && i_sts.last_char;
                if (i_sts.out_free && i_sts.last_char) begin
                    n_state = S_ABSORB;
                end
            end
            default: begin
                n_state = S_ABSORB;
            end
        endcase
    end

    // No byte is taken while the key drains
    a_no_absorb_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.absorb |-> (r_state == S_ABSORB))
        else $error("byte absorbed during drain");

    // Clearing only happens with the final character load
    a_clear_with_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> o_cmd.emit)
        else $error("clear without emit");

endmodule

// ===== rtl/lkfs_dp.sv =====
module lkfs_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lkfs_pkg::t_cmd i_cmd,
    output lkfs_pkg::t_sts o_sts,
    input  logic [7:0]    i_key_byte,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [7:0]    o_out_char,
    output logic          o_was_hashed,
    output logic          o_final_char
);
    import lkfs_pkg::*;

    logic [63:0]      r_hash;
    logic [63:0]      n_hash;
    logic [63:0]      w_mix;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_store [STORE_DEPTH];
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] w_limit_m1;
    logic [IDX_W-1:0] w_sel;
    logic [3:0]       w_nib;
    logic [7:0]       w_char;
    logic             w_hashed;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_hashed;
    logic             r_out_final;

    // FNV-1a step: prime is 2^40 + 0x1B3, so the product is shifts and adds
    assign w_mix  = r_hash ^ {56'd0, i_key_byte};
    assign n_hash = (w_mix << 40) + (w_mix << 8) + (w_mix << 7) + (w_mix << 5)
                  + (w_mix << 4) + (w_mix << 1) + w_mix;

    // Hash accumulator and saturating length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
            r_len  <= '0;
        end else if (i_cmd.clear) begin
            r_hash <= FNV_BASIS;
            r_len  <= '0;
        end else if (i_cmd.absorb) begin
            r_hash <= n_hash;
            if (r_len < LEN_LIMIT) begin
                r_len <= r_len + LEN_W'(1);
            end
        end
    end

    // Short key buffer, first bytes only
    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb && (r_len < LEN_STORE)) begin
            r_store[r_len[IDX_W-1:0]] <= i_key_byte;
        end
    end

    // Emit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.clear) begin
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Character select: buffered byte or hex digit of the low 60 hash bits
    assign w_hashed   = (r_len == LEN_LIMIT);
    assign w_limit_m1 = w_hashed ? IDX_HEX_LAST : (r_len[IDX_W-1:0] - IDX_W'(1));
    assign w_sel      = IDX_HEX_LAST - r_idx;
    assign w_nib      = r_hash[{w_sel, 2'b00} +: 4];
    assign w_char     = w_hashed ? hex_char(w_nib) : r_store[r_idx];

    assign o_sts.out_free  = !r_out_valid || !i_stall;
    assign o_sts.last_char = (r_idx == w_limit_m1);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char   <= w_char;
            r_out_hashed <= w_hashed;
            r_out_final  <= o_sts.last_char;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_was_hashed = r_out_hashed;
    assign o_final_char = r_out_final;

    // Length never passes the limit
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_LIMIT)
        else $error("key length beyond limit");

    // Clear returns hash, length and index to their start values
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_hash == FNV_BASIS) && (r_len == '0) && (r_idx == '0))
        else $error("state not cleared");

    // Emission never runs past the character count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_idx <= w_limit_m1) && (r_len != '0))
        else $error("emit index out of range");

endmodule

// ===== verif/long_key_fnv1a_shortener_tb.sv =====
module long_key_fnv1a_shortener_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lkfs_pkg::*;

    localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_UPPER_A   = 8'h41;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          STUCK_LIMIT  = 3000;
    localparam int          SETTLE_CYCLES = 20;

    // One character of a shortened key
    typedef struct packed {
        logic [7:0] ch;
        logic       hashed;
        logic       last;
    } t_key_char;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_key_byte;
    logic       i_final_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_char;
    logic       o_was_hashed;
    logic       o_final_char;

    // Shadow of the shortener state
    logic [63:0]      fnv_acc;
    logic [LEN_W-1:0] key_len;
    logic [7:0]       key_prefix [STORE_DEPTH];

    t_key_char expected_chars [$];
    int        mismatches;
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        hold_req;
    int        stuck_cycles;

    long_key_fnv1a_shortener i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key_byte   (i_key_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_was_hashed (o_was_hashed),
        .o_final_char (o_final_char)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [7:0] nibble_to_hex(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CH_ZERO + 8'(nib);
        end
        return CH_UPPER_A + 8'(nib - 4'd10);
    endfunction

    task automatic clear_key_state();
        fnv_acc = FNV_BASIS;
        key_len = '0;
        foreach (key_prefix[i]) key_prefix[i] = 8'h00;
    endtask

    // Fold one accepted key byte into the shadow state; on the last byte
    // queue up the characters of the shortened key
    task automatic fold_key_byte(input logic [7:0] b, input logic last);
        t_key_char c;
        int        n;
        fnv_acc = (fnv_acc ^ {56'd0, b}) * FNV_PRIME;
        if (key_len < STORE_DEPTH) begin
            key_prefix[key_len[IDX_W-1:0]] = b;
        end
        if (key_len < KEY_LIMIT) begin
            key_len = key_len + 1'b1;
        end
        if (last) begin
            if (key_len < KEY_LIMIT) begin
                n = int'(key_len);
                for (int i = 0; i < n; i++) begin
                    c.ch     = key_prefix[i];
                    c.hashed = 1'b0;
                    c.last   = (i == n - 1);
                    expected_chars.push_back(c);
                end
            end else begin
                // Low 60 bits of the hash, top digit first
                for (int k = 0; k < HEX_DIGITS; k++) begin
                    c.ch     = nibble_to_hex(4'((fnv_acc >> (4 * (HEX_DIGITS - 1 - k))) & 64'hF));
                    c.hashed = 1'b1;
                    c.last   = (k == HEX_DIGITS - 1);
                    expected_chars.push_back(c);
                end
            end
            clear_key_state();
        end
    endtask

    // Offer one key byte at a falling edge and hold it until taken
    task automatic send_key_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) @(negedge i_clk);
        i_valid      = 1'b1;
        i_key_byte   = b;
        i_final_byte = last;
        do @(posedge i_clk); while (o_stall);
        fold_key_byte(b, last);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_random_key(input int len);
        for (int i = 0; i < len; i++) begin
            send_key_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Single-byte keys at both byte extremes, then the longest key kept as is
    task automatic test_short_keys();
        send_key_byte(8'h00, 1'b1);
        send_key_byte(8'hFF, 1'b1);
        for (int i = 0; i < STORE_DEPTH; i++) begin
            send_key_byte((i % 2) ? 8'hAA : 8'h55, i == STORE_DEPTH - 1);
        end
    endtask

    // Shortest key that gets hashed
    task automatic test_hashed_keys();
        for (int i = 0; i < KEY_LIMIT; i++) begin
            send_key_byte(8'(i * 17), i == KEY_LIMIT - 1);
        end
    endtask

    // Receiver holds off while a long key and a short one are offered
    task automatic test_backpressure();
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        send_random_key(20);
        send_random_key(5);
    endtask

    // Random keys of 1 to 30 bytes: short ones, ones near the length limit and long ones
    task automatic test_random_keys(input int tx_pct, input int rx_pct, input int n_bytes);
        int sent;
        int len;
        int sel;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_bytes) begin
            sel = $urandom_range(9);
            if (sel < 4) begin
                len = $urandom_range(STORE_DEPTH - 1, 1);
            end else if (sel < 6) begin
                len = $urandom_range(KEY_LIMIT + 1, STORE_DEPTH);
            end else begin
                len = $urandom_range(30, KEY_LIMIT + 2);
            end
            send_random_key(len);
            sent += len;
        end
    endtask

    // Receiver: random stall, plus one long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall  = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_stall = ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Compare each character taken from the block with the oldest expectation
    always @(posedge i_clk) begin
        t_key_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character: out_char %h", o_out_char);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("out_char: expected %h, got %h", want.ch, o_out_char);
                    mismatches++;
                end
                if (o_was_hashed !== want.hashed) begin
                    $error("was_hashed: expected %b, got %b", want.hashed, o_was_hashed);
                    mismatches++;
                end
                if (o_final_char !== want.last) begin
                    $error("final_char: expected %b, got %b", want.last, o_final_char);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_key_byte   = 8'h00;
        i_final_byte = 1'b0;
        hold_req     = 1'b0;
        mismatches   = 0;
        stuck_cycles = 0;
        tx_idle_pct  = 20;
        rx_idle_pct  = 66;
        clear_key_state();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_short_keys();
        test_hashed_keys();
        test_backpressure();
        test_random_keys(20, 66, 10);
        test_random_keys(66, 20, 10);
        test_random_keys(0, 0, 10);

        // Let the last key drain out
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lkfs_pkg.sv
rtl/lkfs_ctrl.sv
rtl/lkfs_dp.sv
rtl/long_key_fnv1a_shortener.sv
verif/long_key_fnv1a_shortener_tb.sv
